>>> rtl/vfd_pkg.sv
// shared types, constants and word packing for the vfd command serializer
package vfd_pkg;

    // frame geometry
    localparam int ADDR_BITS       = 8;
    localparam int SHORT_DATA_BITS = 24;
    localparam int LONG_DATA_BITS  = 56;
    localparam int WORD_W          = LONG_DATA_BITS;
    localparam int CNT_W           = $clog2(LONG_DATA_BITS);

    // command modes
    localparam logic [3:0] MODE_BLINK     = 4'd0;
    localparam logic [3:0] MODE_ONOFF     = 4'd1;
    localparam logic [3:0] MODE_SHIFT     = 4'd2;
    localparam logic [3:0] MODE_GRID_LOAD = 4'd3;
    localparam logic [3:0] MODE_SET_ADDR  = 4'd4;
    localparam logic [3:0] MODE_INTENSITY = 4'd5;
    localparam logic [3:0] MODE_CHAR_WR   = 4'd6;
    localparam logic [3:0] MODE_DOT_WR    = 4'd7;
    localparam logic [3:0] MODE_PATTERN   = 4'd8;

    // opcode prefixes placed at the top of the command word
    localparam logic [3:0] OP_BLINK     = 4'h5;
    localparam logic [3:0] OP_ONOFF     = 4'h1;
    localparam logic [3:0] OP_SHIFT     = 4'h2;
    localparam logic [3:0] OP_GRID_LOAD = 4'h3;
    localparam logic [3:0] OP_SET_ADDR  = 4'h4;
    localparam logic [3:0] OP_INTENSITY = 4'h5;
    localparam logic [3:0] OP_CHAR_WR   = 4'h6;
    localparam logic [3:0] OP_DOT_WR    = 4'h7;
    localparam logic [3:0] OP_PATTERN   = 4'h8;

    // one command transaction
    typedef struct packed {
        logic [3:0]  mode;
        logic [1:0]  target_memory;
        logic [2:0]  period;
        logic [15:0] grid_mask;
        logic        flag;
        logic [7:0]  char_address;
        logic [3:0]  dots_address;
        logic [7:0]  data_byte;
        logic [34:0] pattern;
    } t_cmd;

    // one serial bit transaction
    typedef struct packed {
        logic chip_enable;
        logic serial_data;
        logic last;
    } t_bit;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift_addr;
        logic shift_data;
        logic data_phase;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic mode_ok;
        logic addr_done;
        logic data_done;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] pack_word(input t_cmd c);
        logic [WORD_W-1:0] w;
        w = '0;
        case (c.mode)
            MODE_BLINK:     w = (WORD_W'(OP_BLINK) << 21) | (WORD_W'(c.target_memory) << 19)
                              | (WORD_W'(c.period) << 16) | WORD_W'(c.grid_mask);
            MODE_ONOFF:     w = (WORD_W'(OP_ONOFF) << 20) | (WORD_W'(c.target_memory) << 17)
                              | (WORD_W'(c.flag) << 16) | WORD_W'(c.grid_mask);
            MODE_SHIFT:     w = (WORD_W'(OP_SHIFT) << 20) | (WORD_W'(c.target_memory) << 17)
                              | (WORD_W'(c.flag) << 16);
            MODE_GRID_LOAD: w = (WORD_W'(OP_GRID_LOAD) << 20) | (WORD_W'(c.dots_address) << 16);
            MODE_SET_ADDR:  w = (WORD_W'(OP_SET_ADDR) << 20) | (WORD_W'(c.dots_address) << 16)
                              | (WORD_W'(c.char_address[5:0]) << 8);
            MODE_INTENSITY: w = (WORD_W'(OP_INTENSITY) << 20) | (WORD_W'(c.data_byte) << 8);
            MODE_CHAR_WR:   w = (WORD_W'(OP_CHAR_WR) << 20) | (WORD_W'(c.char_address[5:0]) << 8)
                              | WORD_W'(c.data_byte);
            MODE_DOT_WR:    w = (WORD_W'(OP_DOT_WR) << 20) | (WORD_W'(c.dots_address) << 16)
                              | (WORD_W'(c.data_byte) << 8);
            MODE_PATTERN:   w = (WORD_W'(OP_PATTERN) << 52) | (WORD_W'(c.char_address) << 40)
                              | WORD_W'(c.pattern);
            default:        w = '0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/vfd_stream_if.sv
// valid/ready channel interface carrying one payload type
interface vfd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vfd_ctrl.sv
// frame sequencing state machine for the vfd command serializer
module vfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    output logic              o_bit_valid,
    input  logic              i_bit_ready,
    input  vfd_pkg::t_dp_stat i_stat,
    output vfd_pkg::t_dp_ctrl o_ctrl
);
    import vfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADDR = 3'b010,
        S_DATA = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   w_bit_xfer;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_bit_valid = (r_state != S_IDLE);
    assign w_bit_xfer  = o_bit_valid & i_bit_ready;

    // datapath commands
    always_comb begin
        o_ctrl.load       = o_cmd_ready & i_cmd_valid & i_stat.mode_ok;
        o_ctrl.shift_addr = (r_state == S_ADDR) & i_bit_ready;
        o_ctrl.shift_data = (r_state == S_DATA) & i_bit_ready;
        o_ctrl.data_phase = (r_state == S_DATA);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_stat.mode_ok) n_state = S_ADDR;
            end
            S_ADDR: begin
                if (w_bit_xfer && i_stat.addr_done) n_state = S_DATA;
            end
            S_DATA: begin
                if (w_bit_xfer && i_stat.data_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

>>> rtl/vfd_datapath.sv
// address register, command word shifter and bit counter
module vfd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  vfd_pkg::t_cmd     i_cmd,
    input  vfd_pkg::t_dp_ctrl i_ctrl,
    output vfd_pkg::t_dp_stat o_stat,
    output vfd_pkg::t_bit     o_bit
);
    import vfd_pkg::*;

    logic [ADDR_BITS-1:0] r_dev_addr;
    logic [ADDR_BITS-1:0] r_addr_sh;
    logic [WORD_W-1:0]    r_word;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_long;
    logic                 w_last;

    // device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_dev_addr <= '0;
        else if (i_cfg_we) r_dev_addr <= i_cfg_data;
    end

    // frame end detection
    assign w_last = r_long ? (r_cnt == CNT_W'(LONG_DATA_BITS - 1))
                           : (r_cnt == CNT_W'(SHORT_DATA_BITS - 1));

    always_comb begin
        o_stat.mode_ok   = (i_cmd.mode <= MODE_PATTERN);
        o_stat.addr_done = (r_cnt == CNT_W'(ADDR_BITS - 1));
        o_stat.data_done = w_last;
    end

    // shifters and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_long    <= 1'b0;
            r_addr_sh <= '0;
            r_word    <= '0;
        end else if (i_ctrl.load) begin
            r_cnt     <= '0;
            r_long    <= (i_cmd.mode == MODE_PATTERN);
            r_addr_sh <= r_dev_addr;
            r_word    <= pack_word(i_cmd);
        end else if (i_ctrl.shift_addr) begin
            r_addr_sh <= {r_addr_sh[ADDR_BITS-2:0], 1'b0};
            r_cnt     <= (r_cnt == CNT_W'(ADDR_BITS - 1)) ? '0 : r_cnt + 1'b1;
        end else if (i_ctrl.shift_data) begin
            r_word <= {1'b0, r_word[WORD_W-1:1]};
            r_cnt  <= w_last ? '0 : r_cnt + 1'b1;
        end
    end

    // current serial bit
    always_comb begin
        o_bit.chip_enable = i_ctrl.data_phase;
        o_bit.serial_data = i_ctrl.data_phase ? r_word[0] : r_addr_sh[ADDR_BITS-1];
        o_bit.last        = i_ctrl.data_phase & w_last;
    end
endmodule

>>> rtl/vfd_command_serializer.sv
// top level of the vfd command serializer
// usage:
//   i_cmd  : command transaction (mode and fields); taken only while idle
//   o_bit  : one transaction per serial clock pulse: chip_enable, serial_data, last
//   i_cfg  : 8-bit device address write, always ready, write only while idle
// a frame is 8 address bits msb first with chip_enable low, then 24 data bits
// (56 for the pattern write) lsb first with chip_enable high; last marks the
// final data bit
// the first bit is offered in the cycle after the command is taken
// throughput: one bit per cycle from the shift registers while o_bit.ready
// modes above the pattern write are taken and dropped without any bits
// reset: synchronous, active low; returns to idle, device address cleared
// receiver stall: the current bit is held until o_bit.ready, no command is
//   taken until the frame has fully drained
module vfd_command_serializer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vfd_stream_if.sink   i_cmd,
    vfd_stream_if.source o_bit,
    vfd_stream_if.sink   i_cfg
);
    import vfd_pkg::*;

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    assign i_cfg.ready = 1'b1;

    vfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .o_bit_valid (o_bit.valid),
        .i_bit_ready (o_bit.ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    vfd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_cmd      (i_cmd.data),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .o_bit      (o_bit.data)
    );
endmodule

>>> rtl/vfd_checker.sv
// port-level checks for the vfd command serializer and their bind
module vfd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cmd_ready,
    input logic i_bit_valid,
    input logic i_bit_ready,
    input logic i_bit_ce,
    input logic i_bit_data,
    input logic i_bit_last
);
    // last only appears during the data phase
    a_last_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bit_valid && i_bit_last |-> i_bit_ce)
        else $error("last asserted with chip enable low");

    // no command is taken while a frame is on the wire
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bit_valid |-> !i_cmd_ready)
        else $error("command ready during a frame");

    // the frame ends after the last bit transaction
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bit_valid && i_bit_ready && i_bit_last |=> !i_bit_valid)
        else $error("bits continue after last");

    // data phase keeps chip enable high until last
    a_ce_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bit_valid && i_bit_ready && i_bit_ce && !i_bit_last |=> i_bit_valid && i_bit_ce)
        else $error("chip enable dropped before last");

    // a stalled bit holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bit_valid && !i_bit_ready |=> i_bit_valid && $stable(i_bit_ce)
            && $stable(i_bit_data) && $stable(i_bit_last))
        else $error("stalled bit changed");
endmodule

bind vfd_command_serializer vfd_checker u_vfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_bit_valid (o_bit.valid),
    .i_bit_ready (o_bit.ready),
    .i_bit_ce    (o_bit.data.chip_enable),
    .i_bit_data  (o_bit.data.serial_data),
    .i_bit_last  (o_bit.data.last)
);
